// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_ni is high.
`define TSSFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TSSFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/tssfs_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment frame sequencer package
// Types, bus status codes, command codes and the segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package tssfs_pkg;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned UsedW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_START = 2'd3
  } cmd_e;

  localparam logic [CfgIdxW-1:0] REG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INSTRUCTION_VALUE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CONTROL_VALUE     = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DIGITS_IN_USE     = 2'd3;

  localparam logic [ByteW-1:0] RST_DEVICE_ADDRESS    = 8'h70;
  localparam logic [ByteW-1:0] RST_INSTRUCTION_VALUE = 8'h00;
  localparam logic [ByteW-1:0] RST_CONTROL_VALUE     = 8'h47;
  localparam logic [UsedW-1:0] RST_DIGITS_IN_USE     = 3'd4;

  localparam logic [ByteW-1:0] STATUS_MASK  = 8'hF8;
  localparam logic [ByteW-1:0] ST_START     = 8'h08;
  localparam logic [ByteW-1:0] ST_RSTART    = 8'h10;
  localparam logic [ByteW-1:0] ST_ADDR_ACK  = 8'h18;
  localparam logic [ByteW-1:0] ST_ADDR_NACK = 8'h20;
  localparam logic [ByteW-1:0] ST_DATA_ACK  = 8'h28;
  localparam logic [ByteW-1:0] ST_DATA_NACK = 8'h30;
  localparam logic [ByteW-1:0] ST_ARB_LOST  = 8'h38;

  localparam logic ACTION_TICK = 1'b0;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] bus_status;
  } item_t;

  typedef struct packed {
    cmd_e             command;
    logic [ByteW-1:0] tx_byte;
  } res_t;

  typedef struct packed {
    logic [ByteW-1:0] device_address;
    logic [ByteW-1:0] instruction_value;
    logic [ByteW-1:0] control_value;
    logic [UsedW-1:0] digits_in_use;
  } cfg_t;

  function automatic logic [ByteW-1:0] seg_code(input logic [DigitW-1:0] digit);
    logic [ByteW-1:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tssfs_in_if.sv
// ----------------------------------------------------------------------------
// Event channel
// Carries one tick or bus status item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tssfs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] bus_status;

  modport source (output valid, action, bus_status, input ready);
  modport sink (input valid, action, bus_status, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tssfs_out_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Carries one bus command and its byte with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tssfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] tx_byte;

  modport source (output valid, command, tx_byte, input ready);
  modport sink (input valid, command, tx_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tssfs_counter.sv
// ----------------------------------------------------------------------------
// Decimal display counter
// Holds the display digits and advances them by one with decimal carry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tssfs_counter
  import tssfs_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                adv_i,
  output logic       [DIGIT_COUNT-1:0][DigitW-1:0] digits_o
);

  logic [DIGIT_COUNT-1:0][DigitW-1:0] digits_q;
  logic [DIGIT_COUNT-1:0][DigitW-1:0] digits_d;

  // Digit zero is the most significant one; the carry enters at the last.
  always_comb begin
    logic carry;
    carry    = 1'b1;
    digits_d = digits_q;
    for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
      if (carry) begin
        if (digits_q[k] >= DigitW'(9)) begin
          digits_d[k] = '0;
        end else begin
          digits_d[k] = digits_q[k] + DigitW'(1);
          carry       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
    end else if (adv_i) begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_chk
    `TSSFS_ASSERT_ALWAYS(a_digit_decimal, digits_q[g] <= DigitW'(9), "digit above nine")
  end
  `TSSFS_ASSERT(a_hold_without_tick, !adv_i |=> $stable(digits_q), "digits moved without a tick")

endmodule

`default_nettype wire

// File: hw/rtl/tssfs_frame_ctl.sv
// ----------------------------------------------------------------------------
// Frame control
// Decodes one event into a bus command and byte and tracks the frame position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tssfs_frame_ctl
  import tssfs_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire item_t                               item_i,
  input  wire logic                                upd_i,
  input  wire cfg_t                                cfg_i,
  input  wire logic  [DIGIT_COUNT-1:0][DigitW-1:0] digits_i,
  output res_t                                     res_o
);

  localparam int unsigned IdxBits = $clog2(DIGIT_COUNT + 2);
  localparam int unsigned IdxW    = (IdxBits > UsedW) ? IdxBits : UsedW;

  logic [IdxW-1:0]   idx_q;
  logic [IdxW-1:0]   idx_d;
  logic [IdxW-1:0]   used;
  logic [IdxW-1:0]   idx_m1;
  logic [DigitW-1:0] digit_sel;

  assign used = (IdxW'(cfg_i.digits_in_use) > IdxW'(DIGIT_COUNT)) ?
                IdxW'(DIGIT_COUNT) : IdxW'(cfg_i.digits_in_use);
  assign idx_m1 = idx_q - IdxW'(1);

  always_comb begin
    digit_sel = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (idx_m1 == IdxW'(k)) begin
        digit_sel = digits_i[k];
      end
    end
  end

  always_comb begin
    idx_d         = idx_q;
    res_o.command = CMD_NONE;
    res_o.tx_byte = '0;
    if (item_i.action == ACTION_TICK) begin
      res_o.command = CMD_START;
    end else begin
      case (item_i.bus_status & STATUS_MASK)
        ST_START: begin
          res_o.command = CMD_SEND;
          res_o.tx_byte = cfg_i.device_address;
        end
        ST_RSTART: begin
          idx_d         = '0;
          res_o.command = CMD_SEND;
          res_o.tx_byte = cfg_i.device_address;
        end
        ST_ADDR_ACK, ST_ADDR_NACK: begin
          res_o.command = CMD_SEND;
          res_o.tx_byte = cfg_i.instruction_value;
        end
        ST_DATA_ACK: begin
          if (idx_q == '0) begin
            idx_d         = IdxW'(1);
            res_o.command = CMD_SEND;
            res_o.tx_byte = cfg_i.control_value;
          end else if (idx_q <= used) begin
            idx_d         = idx_q + IdxW'(1);
            res_o.command = CMD_SEND;
            res_o.tx_byte = seg_code(digit_sel);
          end else begin
            idx_d         = '0;
            res_o.command = CMD_STOP;
          end
        end
        ST_DATA_NACK, ST_ARB_LOST: begin
          idx_d         = '0;
          res_o.command = CMD_START;
        end
        default: begin
          idx_d = idx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (upd_i) begin
      idx_q <= idx_d;
    end
  end

  `TSSFS_ASSERT_ALWAYS(a_idx_range, idx_q <= IdxW'(DIGIT_COUNT + 1), "frame position out of range")
  `TSSFS_ASSERT(a_stop_clears, (upd_i && res_o.command == CMD_STOP) |=> idx_q == '0, "stop kept position")

endmodule

`default_nettype wire

// File: hw/rtl/twi_seven_segment_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Seven-segment frame sequencer
// Two-wire master sequencer that sends a decimal counter to a display driver.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, back to back, while the command
// side keeps up, and gives exactly one command item for each. An accepted item
// sits in an input register, where a combinational decode produces its command
// and updates the frame position and counter, and the command then waits in an
// output register, from which it is offered. The output register lets a new
// item enter while an earlier command is still waiting to be taken; a stall
// on the command side holds the input side only once both registers are full.
`default_nettype none
`include "assert_macros.svh"

module twi_seven_segment_frame_sequencer
  import tssfs_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  tssfs_in_if.sink                 in_i,
  tssfs_out_if.source              out_o
);

  cfg_t  cfg_q;
  item_t item_q;
  logic  item_vld_q;
  res_t  res_q;
  logic  res_vld_q;
  res_t  res_d;
  logic  adv;
  logic  in_ready;
  logic  in_fire;
  logic  full_stall;
  logic  [DIGIT_COUNT-1:0][DigitW-1:0] digits;

  assign adv        = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_ready   = !item_vld_q || adv;
  assign in_fire    = in_i.valid && in_ready;
  assign full_stall = item_vld_q && res_vld_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= RST_DEVICE_ADDRESS;
      cfg_q.instruction_value <= RST_INSTRUCTION_VALUE;
      cfg_q.control_value     <= RST_CONTROL_VALUE;
      cfg_q.digits_in_use     <= RST_DIGITS_IN_USE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEVICE_ADDRESS:    cfg_q.device_address    <= cfg_data_i;
        REG_INSTRUCTION_VALUE: cfg_q.instruction_value <= cfg_data_i;
        REG_CONTROL_VALUE:     cfg_q.control_value     <= cfg_data_i;
        REG_DIGITS_IN_USE:     cfg_q.digits_in_use     <= cfg_data_i[UsedW-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_vld_q <= 1'b1;
      end else if (adv) begin
        item_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.action     <= in_i.action;
      item_q.bus_status <= in_i.bus_status;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  tssfs_counter #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_counter (
    .clk_i,
    .rst_ni,
    .adv_i    (adv && (item_q.action == ACTION_TICK)),
    .digits_o (digits)
  );

  tssfs_frame_ctl #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_frame_ctl (
    .clk_i,
    .rst_ni,
    .item_i   (item_q),
    .upd_i    (adv && (item_q.action != ACTION_TICK)),
    .cfg_i    (cfg_q),
    .digits_i (digits),
    .res_o    (res_d)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = res_vld_q;
  assign out_o.command = res_q.command;
  assign out_o.tx_byte = res_q.tx_byte;

  `TSSFS_ASSERT(a_full_blocks_input, full_stall |-> !in_ready, "input taken while full")
  `TSSFS_ASSERT(a_advance_fills_output, adv |=> res_vld_q, "decoded item not held for output")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Seven-segment frame sequencer testbench
// Drives ticks and bus status items into the sequencer and checks every
// command item against an in-bench model of the frame position, the decimal
// counter and the registers. A short directed table comes first. Random frames
// follow under several register settings, with random gaps and stalls, a long
// output hold, and a back-to-back run of ticks and frames at the end.
// ----------------------------------------------------------------------------
module testbench;
  import tssfs_pkg::*;

  localparam int DIGITS = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 80;
  localparam int BURST_TICKS = 24;
  localparam logic ACTION_BUS = ~ACTION_TICK;
  localparam logic [15:0][7:0] GLYPHS = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };
  localparam int PLAN_ROWS = 21;

  typedef struct packed {
    logic             action;
    logic [ByteW-1:0] status;
    logic             known;
    cmd_e             cmd;
    logic [ByteW-1:0] tx;
  } row_t;

  row_t plan [PLAN_ROWS] = '{
    '{ACTION_BUS,  8'h00,                1'b1, CMD_NONE,  8'h00},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b1, CMD_SEND,  RST_CONTROL_VALUE},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b1, CMD_SEND,  8'h3F},
    '{ACTION_TICK, 8'h00,                1'b1, CMD_START, 8'h00},
    '{ACTION_BUS,  ST_START,             1'b1, CMD_SEND,  RST_DEVICE_ADDRESS},
    '{ACTION_BUS,  ST_ADDR_ACK | 8'h07,  1'b1, CMD_SEND,  RST_INSTRUCTION_VALUE},
    '{ACTION_BUS,  ST_ADDR_NACK,         1'b1, CMD_SEND,  RST_INSTRUCTION_VALUE},
    '{ACTION_BUS,  ST_DATA_ACK | 8'h07,  1'b1, CMD_SEND,  8'h3F},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b0, CMD_NONE,  8'h00},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b1, CMD_SEND,  8'h06},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b1, CMD_STOP,  8'h00},
    '{ACTION_BUS,  ST_DATA_NACK,         1'b1, CMD_START, 8'h00},
    '{ACTION_BUS,  ST_ARB_LOST | 8'h05,  1'b1, CMD_START, 8'h00},
    '{ACTION_BUS,  ST_RSTART,            1'b1, CMD_SEND,  RST_DEVICE_ADDRESS},
    '{ACTION_BUS,  8'hFF,                1'b1, CMD_NONE,  8'h00},
    '{ACTION_BUS,  8'h40,                1'b1, CMD_NONE,  8'h00},
    '{ACTION_BUS,  ST_RSTART | 8'h07,    1'b0, CMD_NONE,  8'h00},
    '{ACTION_TICK, 8'hFF,                1'b1, CMD_START, 8'h00},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b0, CMD_NONE,  8'h00},
    '{ACTION_BUS,  ST_DATA_ACK,          1'b0, CMD_NONE,  8'h00},
    '{ACTION_BUS,  ST_DATA_NACK | 8'h07, 1'b0, CMD_NONE,  8'h00}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tssfs_in_if  ev_ch ();
  tssfs_out_if cmd_ch ();

  twi_seven_segment_frame_sequencer #(.DIGIT_COUNT(DIGITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (ev_ch),
    .out_o      (cmd_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cfg_t             cfg_now;
  logic [2:0]       frame_pos;
  logic [DigitW-1:0] counter_now [DIGITS];
  res_t             pending_cmds [$];

  bit gaps_on;
  bit stalls_on;
  bit hold_pending;
  int faults;
  int items_sent;
  int ticks_sent;
  int frames_sent;
  int results_seen;
  int settings_used;
  int wraps_seen;
  int holds_done;
  int quiet;

  // Counts up the decimal counter; the last digit is the least significant.
  function automatic void bump_counter();
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (counter_now[k] >= 4'd9) begin
        counter_now[k] = '0;
      end else begin
        counter_now[k] = counter_now[k] + 4'd1;
        return;
      end
    end
    wraps_seen++;
  endfunction

  function automatic res_t predict_command(logic act, logic [ByteW-1:0] st);
    res_t r;
    int   used;
    r.command = CMD_NONE;
    r.tx_byte = '0;
    used = (cfg_now.digits_in_use > DIGITS) ? DIGITS : int'(cfg_now.digits_in_use);
    if (act == ACTION_TICK) begin
      r.command = CMD_START;
      bump_counter();
    end else begin
      case (st & STATUS_MASK)
        ST_START: begin
          r.command = CMD_SEND;
          r.tx_byte = cfg_now.device_address;
        end
        ST_RSTART: begin
          frame_pos = '0;
          r.command = CMD_SEND;
          r.tx_byte = cfg_now.device_address;
        end
        ST_ADDR_ACK, ST_ADDR_NACK: begin
          r.command = CMD_SEND;
          r.tx_byte = cfg_now.instruction_value;
        end
        ST_DATA_ACK: begin
          if (frame_pos == 0) begin
            r.command = CMD_SEND;
            r.tx_byte = cfg_now.control_value;
            frame_pos = 3'd1;
          end else if (int'(frame_pos) <= used) begin
            r.command = CMD_SEND;
            r.tx_byte = GLYPHS[counter_now[frame_pos - 3'd1]];
            frame_pos = frame_pos + 3'd1;
          end else begin
            frame_pos = '0;
            r.command = CMD_STOP;
          end
        end
        ST_DATA_NACK, ST_ARB_LOST: begin
          frame_pos = '0;
          r.command = CMD_START;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] with_noise(logic [ByteW-1:0] code);
    return code | ByteW'($urandom_range(7, 0));
  endfunction

  task automatic offer(input logic act, input logic [ByteW-1:0] st, input logic known,
                       input res_t want);
    int   gap;
    res_t guess;
    gap = gaps_on ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_ch.valid      <= 1'b1;
    ev_ch.action     <= act;
    ev_ch.bus_status <= st;
    do @(posedge clk_i); while (!ev_ch.ready);
    guess = predict_command(act, st);
    pending_cmds.push_back(known ? want : guess);
    items_sent++;
    if (act == ACTION_TICK) ticks_sent++;
  endtask

  task automatic send_event(input logic [ByteW-1:0] st);
    offer(ACTION_BUS, st, 1'b0, '0);
  endtask

  task automatic send_tick();
    offer(ACTION_TICK, ByteW'($urandom_range(255, 0)), 1'b0, '0);
  endtask

  task automatic wait_for_results();
    ev_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c, input logic [4:0] spare);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] val [4];
    idx = '{REG_DEVICE_ADDRESS, REG_INSTRUCTION_VALUE, REG_CONTROL_VALUE, REG_DIGITS_IN_USE};
    val = '{c.device_address, c.instruction_value, c.control_value, {spare, c.digits_in_use}};
    wait_for_results();
    for (int k = 0; k < 4; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[k];
      cfg_data <= val[k];
      @(posedge clk_i);
    end
    cfg_we  <= 1'b0;
    cfg_now = c;
    settings_used++;
  endtask

  // One frame as a display update goes: tick, start, address, then data
  // acknowledges through control, digits and stop. Some frames lose the bus
  // or see a data NACK partway and are restarted with a repeated start.
  task automatic run_frame();
    int n_data;
    int cut;
    n_data = ((cfg_now.digits_in_use > DIGITS) ? DIGITS : int'(cfg_now.digits_in_use)) + 2;
    cut = ($urandom_range(3, 0) == 0) ? $urandom_range(n_data - 1, 0) : -1;
    send_tick();
    send_event(with_noise(ST_START));
    send_event(with_noise($urandom_range(1, 0) ? ST_ADDR_ACK : ST_ADDR_NACK));
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(15, 0) == 0) begin
        offer(logic'($urandom_range(1, 0)), ByteW'($urandom_range(255, 0)), 1'b0, '0);
      end
      if (i == cut) begin
        send_event(with_noise($urandom_range(1, 0) ? ST_DATA_NACK : ST_ARB_LOST));
        send_event(with_noise(ST_RSTART));
        send_event(with_noise(ST_ADDR_ACK));
        cut = -1;
        i = -1;
      end else begin
        send_event(with_noise(ST_DATA_ACK));
      end
    end
    frames_sent++;
  endtask

  task automatic run_phase(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      case ($urandom_range(9, 0))
        0: begin
          for (int n = $urandom_range(4, 1); n > 0; n--) begin
            offer(logic'($urandom_range(1, 0)), ByteW'($urandom_range(255, 0)), 1'b0, '0);
          end
        end
        1: begin
          send_tick();
          for (int n = $urandom_range(3, 0); n > 0; n--) send_event(with_noise(ST_DATA_ACK));
        end
        default: run_frame();
      endcase
      if ($urandom_range(19, 0) == 0) wait_for_results();
    end
  endtask

  // Result side: random stall per item, or one long hold when asked for.
  initial begin
    int   stall;
    res_t want;
    res_t got;
    cmd_ch.ready <= 1'b0;
    forever begin
      if (hold_pending) begin
        stall = HOLD_CYCLES;
        hold_pending = 1'b0;
        holds_done++;
      end else begin
        stall = stalls_on ? $urandom_range(19, 0) : 0;
      end
      if (stall > 0) begin
        cmd_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      cmd_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(cmd_ch.valid && cmd_ch.ready));
      got.command = cmd_e'(cmd_ch.command);
      got.tx_byte = cmd_ch.tx_byte;
      results_seen++;
      if (pending_cmds.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected command item: command %0d, byte 0x%02h",
                   got.command, got.tx_byte);
        end
      end else begin
        want = pending_cmds.pop_front();
        if (got.command !== want.command) begin
          faults++;
          if (faults <= 10) begin
            $display("command mismatch at result %0d: expected %0d, got %0d",
                     results_seen, want.command, got.command);
          end
        end
        if (got.tx_byte !== want.tx_byte) begin
          faults++;
          if (faults <= 10) begin
            $display("tx_byte mismatch at result %0d: expected 0x%02h, got 0x%02h",
                     results_seen, want.tx_byte, got.tx_byte);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((ev_ch.valid && ev_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    ev_ch.valid      <= 1'b0;
    ev_ch.action     <= ACTION_TICK;
    ev_ch.bus_status <= '0;
    cfg_now = '{RST_DEVICE_ADDRESS, RST_INSTRUCTION_VALUE, RST_CONTROL_VALUE,
                RST_DIGITS_IN_USE};
    frame_pos = '0;
    foreach (counter_now[k]) counter_now[k] = '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      offer(plan[r].action, plan[r].status, plan[r].known, '{plan[r].cmd, plan[r].tx});
    end

    for (int p = 0; p < 8; p++) begin
      c.device_address    = ByteW'($urandom_range(255, 0));
      c.instruction_value = ByteW'($urandom_range(255, 0));
      c.control_value     = ByteW'($urandom_range(255, 0));
      case (p)
        0: c = '{8'h00, 8'h00, 8'h00, 3'd0};
        1: c = '{8'hFF, 8'hFF, 8'hFF, 3'd4};
        2: c.digits_in_use = 3'd1;
        3: c.digits_in_use = 3'd2;
        4: c.digits_in_use = 3'd3;
        5: c.digits_in_use = 3'd5;
        6: c.digits_in_use = 3'd7;
        default: c.digits_in_use = 3'd6;
      endcase
      load_settings(c, 5'($urandom_range(31, 0)));
      gaps_on   = (p % 3 != 2);
      stalls_on = (p % 4 != 1);
      if (p == 3) begin
        // The result side holds off while items keep coming back to back.
        gaps_on = 1'b0;
        hold_pending = 1'b1;
        run_frame();
        run_frame();
        gaps_on = 1'b1;
      end
      run_phase(PHASE_ITEMS);
    end

    // Ticks and frames back to back with no gaps and no stalls.
    wait_for_results();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int k = 0; k < BURST_TICKS; k++) begin
      if (k % 8 == 0) run_frame();
      else send_tick();
    end
    run_frame();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (pending_cmds.size() != 0) begin
      faults++;
      $display("%0d command items never arrived", pending_cmds.size());
    end
    $display("Sent %0d items (%0d ticks, %0d frames) under %0d register settings.",
             items_sent, ticks_sent, frames_sent, settings_used);
    $display("Checked %0d command items; counter wrapped %0d times; %0d long holds.",
             results_seen, wraps_seen, holds_done);
    if (faults == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
